@@ hw/rtl/umrx_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// umrx_pkg
// Types, codes and the CIN length table of the USB-MIDI event packet receiver.
// ----------------------------------------------------------------------------
package umrx_pkg;

  localparam int QUEUE_DEPTH  = 16;
  localparam int PACKET_BYTES = 4;
  localparam int IDX_W        = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int FILL_W       = $clog2(QUEUE_DEPTH + 1);
  localparam int LEVEL_W      = 5;

  localparam logic [7:0] SYSEX_BEGIN = 8'hF0;
  localparam logic [7:0] SYSEX_EOX   = 8'hF7;

  typedef enum logic {
    OP_RECV = 1'b0,
    OP_POP  = 1'b1
  } op_t;

  typedef enum logic [2:0] {
    ST_QUEUED   = 3'd0,
    ST_MISROUTE = 3'd1,
    ST_MISC     = 3'd2,
    ST_CABLE    = 3'd3,
    ST_FULL     = 3'd4,
    ST_POPPED   = 3'd5,
    ST_EMPTY    = 3'd6
  } status_t;

  typedef enum logic [1:0] {
    TAG_NONE  = 2'd0,
    TAG_START = 2'd1,
    TAG_MID   = 2'd2,
    TAG_END   = 2'd3
  } tag_t;

  // code index numbers
  localparam logic [3:0] CIN_MISC          = 4'h0;
  localparam logic [3:0] CIN_CABLE         = 4'h1;
  localparam logic [3:0] CIN_COMMON2       = 4'h2;
  localparam logic [3:0] CIN_SYSEX_START   = 4'h4;
  localparam logic [3:0] CIN_SYSEX_END1    = 4'h5;
  localparam logic [3:0] CIN_SYSEX_END2    = 4'h6;
  localparam logic [3:0] CIN_SYSEX_END3    = 4'h7;
  localparam logic [3:0] CIN_PROG_CHANGE   = 4'hC;
  localparam logic [3:0] CIN_CHAN_PRESSURE = 4'hD;
  localparam logic [3:0] CIN_SINGLE_BYTE   = 4'hF;

  typedef struct packed {
    op_t        opcode;
    logic [7:0] header_byte;
    logic [7:0] pkt_byte1;
    logic [7:0] pkt_byte2;
    logic [7:0] pkt_byte3;
  } umrx_in_t;

  typedef struct packed {
    status_t            status;
    logic               bad_sysex_start;
    logic               missing_eox;
    logic [7:0]         msg_byte0;
    logic [7:0]         msg_byte1;
    logic [7:0]         msg_byte2;
    logic [1:0]         msg_len;
    tag_t               msg_tag;
    logic [LEVEL_W-1:0] queue_level;
  } umrx_out_t;

  typedef struct packed {
    logic [7:0] b0;
    logic [7:0] b1;
    logic [7:0] b2;
    logic [1:0] len;
    tag_t       tag;
  } entry_t;

  function automatic logic [1:0] cin_len(input logic [3:0] cin);
    logic [1:0] len;
    len = 2'd3;
    case (cin) inside
      CIN_COMMON2, CIN_SYSEX_END2, CIN_PROG_CHANGE, CIN_CHAN_PRESSURE: len = 2'd2;
      CIN_SYSEX_END1, CIN_SINGLE_BYTE:                                 len = 2'd1;
      default:                                                         len = 2'd3;
    endcase
    return len;
  endfunction

endpackage
`default_nettype wire

@@ hw/rtl/usb_midi_event_packet_receiver_top.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// usb_midi_event_packet_receiver_top
// USB-MIDI 1.0 event packet receiver with a message queue.
//
// Input channel (in_valid/in_ready/in_data): one request per beat, either a
// received 4-byte event packet or a pop of the oldest queued message.
// Result channel (out_valid/out_ready/out_data): exactly one result per
// request, in request order.
// Config: cfg_wr_en/cfg_wr_data sets the own cable number; the user must
// write it only while the block is idle, which the block does not enforce.
// Path: an accepted request goes from the input register through one pass
// of packet/queue logic into the result register. Throughput: one request
// per cycle while out_ready is high.
// The queue lives in flip-flops and is read at the head in the same pass.
// Stall: when out_ready is low and the result register is full, the input
// register holds and in_ready drops once it is full too; nothing is lost.
// Reset: own cable 0, SysEx run flag clear, queue empty, both channels idle.
// ----------------------------------------------------------------------------
module usb_midi_event_packet_receiver_top (
  input  wire                      clk,
  input  wire                      rst_n,
  input  wire                      in_valid,
  output logic                     in_ready,
  input  wire umrx_pkg::umrx_in_t  in_data,
  output logic                     out_valid,
  input  wire                      out_ready,
  output umrx_pkg::umrx_out_t      out_data,
  input  wire                      cfg_wr_en,
  input  wire  [3:0]               cfg_wr_data
);

  localparam int SUM_W = umrx_pkg::FILL_W + 1;

  logic                          req_valid_r;
  umrx_pkg::umrx_in_t            req_r;
  logic                          out_valid_r;
  umrx_pkg::umrx_out_t           out_r;
  logic [3:0]                    own_cable_r;
  logic                          run_r;
  logic                          run_nxt;
  logic [umrx_pkg::IDX_W-1:0]    head_r;
  logic [umrx_pkg::IDX_W-1:0]    head_nxt;
  logic [umrx_pkg::FILL_W-1:0]   fill_r;
  logic [umrx_pkg::FILL_W-1:0]   fill_nxt;
  umrx_pkg::entry_t              queue_r [umrx_pkg::QUEUE_DEPTH];

  logic                          advance;
  umrx_pkg::umrx_out_t           res;
  umrx_pkg::entry_t              wr_entry;
  logic                          wr_en;
  logic [SUM_W-1:0]              tail_sum;
  logic [umrx_pkg::IDX_W-1:0]    tail;
  logic [3:0]                    cin;
  logic [1:0]                    len;
  logic [7:0]                    last_byte;
  logic                          is_end;
  umrx_pkg::entry_t              head_entry;

  assign advance   = !out_valid_r || out_ready;
  assign in_ready  = !req_valid_r || advance;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  assign cin        = req_r.header_byte[3:0];
  assign len        = umrx_pkg::cin_len(cin);
  assign head_entry = queue_r[head_r];

  always_comb begin
    tail_sum = SUM_W'(head_r) + SUM_W'(fill_r);
    if (tail_sum >= SUM_W'(umrx_pkg::QUEUE_DEPTH)) begin
      tail_sum = tail_sum - SUM_W'(umrx_pkg::QUEUE_DEPTH);
    end
    tail = tail_sum[umrx_pkg::IDX_W-1:0];
  end

  always_comb begin
    case (len)
      2'd1:    last_byte = req_r.pkt_byte1;
      2'd2:    last_byte = req_r.pkt_byte2;
      default: last_byte = req_r.pkt_byte3;
    endcase
  end

  always_comb begin
    res      = '0;
    run_nxt  = run_r;
    head_nxt = head_r;
    fill_nxt = fill_r;
    wr_en    = 1'b0;
    is_end   = 1'b0;
    wr_entry.b0  = req_r.pkt_byte1;
    wr_entry.b1  = (len > 2'd1) ? req_r.pkt_byte2 : 8'h00;
    wr_entry.b2  = (len > 2'd2) ? req_r.pkt_byte3 : 8'h00;
    wr_entry.len = len;
    wr_entry.tag = umrx_pkg::TAG_NONE;

    if (req_r.opcode == umrx_pkg::OP_POP) begin
      if (fill_r == '0) begin
        res.status = umrx_pkg::ST_EMPTY;
      end else begin
        res.status    = umrx_pkg::ST_POPPED;
        res.msg_byte0 = head_entry.b0;
        res.msg_byte1 = head_entry.b1;
        res.msg_byte2 = head_entry.b2;
        res.msg_len   = head_entry.len;
        res.msg_tag   = head_entry.tag;
        head_nxt = (head_r == umrx_pkg::IDX_W'(umrx_pkg::QUEUE_DEPTH - 1)) ?
                   '0 : head_r + 1'b1;
        fill_nxt = fill_r - 1'b1;
      end
    end else if (req_r.header_byte[7:4] != own_cable_r) begin
      res.status = umrx_pkg::ST_MISROUTE;
    end else if (cin == umrx_pkg::CIN_MISC) begin
      res.status = umrx_pkg::ST_MISC;
    end else if (cin == umrx_pkg::CIN_CABLE) begin
      res.status = umrx_pkg::ST_CABLE;
    end else begin
      if (cin == umrx_pkg::CIN_SYSEX_START) begin
        if (!run_r) begin
          res.bad_sysex_start = (req_r.pkt_byte1 != umrx_pkg::SYSEX_BEGIN);
          run_nxt             = 1'b1;
          wr_entry.tag        = umrx_pkg::TAG_START;
        end else begin
          wr_entry.tag = umrx_pkg::TAG_MID;
        end
      end else if (cin == umrx_pkg::CIN_SYSEX_END2 || cin == umrx_pkg::CIN_SYSEX_END3) begin
        is_end = 1'b1;
      end else if (cin == umrx_pkg::CIN_SYSEX_END1) begin
        is_end = run_r || (req_r.pkt_byte1 == umrx_pkg::SYSEX_EOX);
      end

      if (is_end) begin
        res.missing_eox = (last_byte != umrx_pkg::SYSEX_EOX);
        wr_entry.tag    = (!run_r && req_r.pkt_byte1 == umrx_pkg::SYSEX_BEGIN) ?
                          umrx_pkg::TAG_NONE : umrx_pkg::TAG_END;
        run_nxt         = 1'b0;
      end

      if (fill_r >= umrx_pkg::FILL_W'(umrx_pkg::QUEUE_DEPTH)) begin
        res.status = umrx_pkg::ST_FULL;
      end else begin
        res.status = umrx_pkg::ST_QUEUED;
        wr_en      = 1'b1;
        fill_nxt   = fill_r + 1'b1;
      end
    end
    res.queue_level = umrx_pkg::LEVEL_W'(fill_nxt);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      req_valid_r <= 1'b0;
      out_valid_r <= 1'b0;
      own_cable_r <= '0;
      run_r       <= 1'b0;
      head_r      <= '0;
      fill_r      <= '0;
    end else begin
      if (cfg_wr_en) begin
        own_cable_r <= cfg_wr_data;
      end
      if (in_ready) begin
        req_valid_r <= in_valid;
      end
      if (advance) begin
        out_valid_r <= req_valid_r;
        if (req_valid_r) begin
          run_r  <= run_nxt;
          head_r <= head_nxt;
          fill_r <= fill_nxt;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      req_r <= in_data;
    end
    if (advance && req_valid_r) begin
      out_r <= res;
    end
    if (advance && req_valid_r && wr_en) begin
      queue_r[tail] <= wr_entry;
    end
  end

  // checks
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= umrx_pkg::FILL_W'(umrx_pkg::QUEUE_DEPTH))
    else $error("queue fill beyond depth");

  a_pop_len: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_r.status == umrx_pkg::ST_POPPED) |-> (out_r.msg_len != 2'd0))
    else $error("popped entry with zero length");

  a_queued_level: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_r.status == umrx_pkg::ST_QUEUED) |-> (out_r.queue_level != '0))
    else $error("queued result with empty queue level");

  a_stall_only: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> (req_valid_r && out_valid_r && !out_ready))
    else $error("input stalled without a full pipeline");

  a_fill_step: assert property (@(posedge clk) disable iff (!rst_n)
    !(advance && req_valid_r) |=> $stable(fill_r))
    else $error("queue fill moved without a request");

endmodule
`default_nettype wire
